[sv/fal_pkg.sv]
package fal_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int UNIT_BYTES = 4;
    localparam int IDX_W      = $clog2(HEAP_UNITS);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int ADDR_W     = 20;
    localparam int COUNT_W    = 16;
    localparam int NEED_W     = 15;
    localparam int FREE_W     = 15;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_UNITS = 2'd1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [SIZE_W-1:0] MIN_UNITS = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_UNITS = SIZE_W'(HEAP_UNITS);

    typedef struct packed {
        logic              func;
        logic [COUNT_W-1:0] byte_count;
        logic [ADDR_W-1:0]  release_address;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_address;
        logic [FREE_W-1:0] free_bytes;
    } rsp_t;

endpackage

[sv/free_list_heap_allocator.sv]
// First-fit circular free-list allocator over a heap of 4-byte units, with
// the block headers (size, next) held in two on-chip memories of 4096 entries
// sharing one read address, with registered read data. One transaction is in
// work at a time; the memory read port is the walk, visiting one free block
// per cycle. An allocate runs start, first, check (once per visited block),
// split, done; it stops at start on an empty list or at check if none fits.
// A free runs header, walk, join, previous join, done; it stops at walk if no
// place is found, at header on an empty list or bad header, and at idle on a
// bad address. Each transaction returns to idle before the next is taken. A
// result waits in done while the output register is full and stalled.
// Register writes are taken only while idle and hold the input off. The list
// is formed on the first allocate after reset or a register write.
module free_list_heap_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fal_pkg::req_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fal_pkg::rsp_t                      out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fal_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fal_pkg::ADDR_W-1:0]         cfg_data
);
    import fal_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_A_START = 11'b00000000010,
        S_A_FIRST = 11'b00000000100,
        S_A_CHK   = 11'b00000001000,
        S_A_SPLIT = 11'b00000010000,
        S_F_HDR   = 11'b00000100000,
        S_F_WALK  = 11'b00001000000,
        S_F_JOIN  = 11'b00010000000,
        S_F_PJ    = 11'b00100000000,
        S_DONE    = 11'b01000000000,
        S_SPARE   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                formed_reg, formed_next;
    logic                empty_reg, empty_next;
    logic [IDX_W-1:0]    rover_reg, rover_next;
    logic [SIZE_W-1:0]   free_reg, free_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [SIZE_W-1:0]   units_reg, units_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    blk_reg, blk_next;
    logic [SIZE_W-1:0]   steps_reg, steps_next;
    logic [IDX_W-1:0]    bp_reg, bp_next;
    logic [SIZE_W-1:0]   bsz_reg, bsz_next;
    logic [SIZE_W-1:0]   sizep_reg, sizep_next;
    logic [SIZE_W-1:0]   nbsz_reg, nbsz_next;
    logic [IDX_W-1:0]    nbnext_reg, nbnext_next;
    logic                okp_reg, okp_next;
    logic [ADDR_W-1:0]   addrp_reg, addrp_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;

    logic [SIZE_W-1:0]   size_mem [HEAP_UNITS];
    logic [IDX_W-1:0]    next_mem [HEAP_UNITS];
    logic [SIZE_W-1:0]   size_q;
    logic [IDX_W-1:0]    next_q;
    logic [IDX_W-1:0]    rd_addr;
    logic                sz_we, nx_we;
    logic [IDX_W-1:0]    sz_wa, nx_wa;
    logic [SIZE_W-1:0]   sz_wd;
    logic [IDX_W-1:0]    nx_wd;

    logic                in_acc;
    logic [NEED_W-1:0]   need_in;
    logic [ADDR_W-1:0]   rel;
    logic [ADDR_W-3:0]   bp_wide;
    logic [SIZE_W-1:0]   cfg_units;
    logic [SIZE_W:0]     bp_end;
    logic [SIZE_W:0]     free_sum;
    logic [SIZE_W:0]     p_end;
    logic [IDX_W-1:0]    split_blk;
    logic [SIZE_W-1:0]   blk_plus1;
    logic                walk_hit;

    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            size_mem[sz_wa] <= sz_wd;
        end
        size_q <= size_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wa] <= nx_wd;
        end
        next_q <= next_mem[rd_addr];
    end

    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_acc    = in_valid && !in_stall;

    assign need_in   = NEED_W'((({1'b0, in_data.byte_count} + 17'd3) >> 2) + 17'd1);
    assign rel       = in_data.release_address - base_reg;
    assign bp_wide   = rel[ADDR_W-1:2] - 18'd1;
    assign cfg_units = (cfg_data[SIZE_W-1:0] < MIN_UNITS) ? MIN_UNITS :
                       (cfg_data[SIZE_W-1:0] > MAX_UNITS) ? MAX_UNITS : cfg_data[SIZE_W-1:0];
    assign bp_end    = {1'b0, 1'b0, bp_reg} + {1'b0, size_q};
    assign free_sum  = {1'b0, free_reg} + {1'b0, bsz_reg};
    assign p_end     = {1'b0, 1'b0, p_reg} + {1'b0, sizep_reg};
    assign split_blk = IDX_W'({1'b0, p_reg} + size_q - need_reg[SIZE_W-1:0]);
    assign blk_plus1 = {1'b0, blk_reg} + SIZE_W'(1);
    assign walk_hit  = ((bp_reg > p_reg) && (bp_reg < next_q)) ||
                       ((p_reg >= next_q) && ((bp_reg > p_reg) || (bp_reg < next_q)));

    always_comb
    begin
        state_next     = state_reg;
        formed_next    = formed_reg;
        empty_next     = empty_reg;
        rover_next     = rover_reg;
        free_next      = free_reg;
        base_next      = base_reg;
        units_next     = units_reg;
        need_next      = need_reg;
        prev_next      = prev_reg;
        p_next         = p_reg;
        blk_next       = blk_reg;
        steps_next     = steps_reg;
        bp_next        = bp_reg;
        bsz_next       = bsz_reg;
        sizep_next     = sizep_reg;
        nbsz_next      = nbsz_reg;
        nbnext_next    = nbnext_reg;
        okp_next       = okp_reg;
        addrp_next     = addrp_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = rover_reg;
        sz_we          = 1'b0;
        sz_wa          = p_reg;
        sz_wd          = size_q;
        nx_we          = 1'b0;
        nx_wa          = p_reg;
        nx_wd          = next_q;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = bp_wide[IDX_W-1:0];
                if (cfg_valid)
                begin
                    if (cfg_index == CFG_HEAP_BASE)
                    begin
                        base_next   = cfg_data;
                        formed_next = 1'b0;
                        empty_next  = 1'b0;
                        free_next   = units_reg;
                    end
                    else if (cfg_index == CFG_HEAP_UNITS)
                    begin
                        units_next  = cfg_units;
                        formed_next = 1'b0;
                        empty_next  = 1'b0;
                        free_next   = cfg_units;
                    end
                end
                else if (in_acc)
                begin
                    okp_next   = 1'b0;
                    addrp_next = '0;
                    bp_next    = bp_wide[IDX_W-1:0];
                    if (in_data.func == FUNC_ALLOC)
                    begin
                        need_next  = need_in;
                        state_next = S_A_START;
                        if (!formed_reg)
                        begin
                            sz_we       = 1'b1;
                            sz_wa       = '0;
                            sz_wd       = units_reg;
                            nx_we       = 1'b1;
                            nx_wa       = '0;
                            nx_wd       = '0;
                            rover_next  = '0;
                            formed_next = 1'b1;
                            empty_next  = 1'b0;
                            free_next   = units_reg;
                        end
                    end
                    else if (!formed_reg || (rel < ADDR_W'(UNIT_BYTES)) || (rel[1:0] != 2'b00)
                             || ({2'b00, bp_wide} >= {{(ADDR_W-SIZE_W){1'b0}}, units_reg}))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_F_HDR;
                    end
                end
            end

            S_A_START:
            begin
                if (empty_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_FIRST;
                end
            end

            S_A_FIRST:
            begin
                rd_addr    = next_q;
                prev_next  = rover_reg;
                p_next     = next_q;
                steps_next = '0;
                state_next = S_A_CHK;
            end

            S_A_CHK:
            begin
                rd_addr = next_q;
                if ({{(NEED_W-SIZE_W){1'b0}}, size_q} >= need_reg)
                begin
                    rover_next = prev_reg;
                    free_next  = ({{(NEED_W-SIZE_W){1'b0}}, free_reg} > need_reg) ?
                                 free_reg - need_reg[SIZE_W-1:0] : '0;
                    okp_next   = 1'b1;
                    if ({{(NEED_W-SIZE_W){1'b0}}, size_q} == need_reg)
                    begin
                        blk_next = p_reg;
                        if (p_reg == prev_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            nx_we = 1'b1;
                            nx_wa = prev_reg;
                            nx_wd = next_q;
                        end
                        state_next = S_A_SPLIT;
                    end
                    else
                    begin
                        sz_we      = 1'b1;
                        sz_wa      = p_reg;
                        sz_wd      = size_q - need_reg[SIZE_W-1:0];
                        blk_next   = split_blk;
                        state_next = S_A_SPLIT;
                    end
                end
                else if ((p_reg == rover_reg) || (steps_reg == units_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next  = p_reg;
                    p_next     = next_q;
                    steps_next = steps_reg + SIZE_W'(1);
                end
            end

            S_A_SPLIT:
            begin
                if (blk_reg != p_reg)
                begin
                    sz_we = 1'b1;
                    sz_wa = blk_reg;
                    sz_wd = need_reg[SIZE_W-1:0];
                end
                addrp_next = base_reg + {{(ADDR_W-SIZE_W-2){1'b0}}, blk_plus1, 2'b00};
                state_next = S_DONE;
            end

            S_F_HDR:
            begin
                bsz_next = size_q;
                if ((size_q == '0) || (bp_end > {1'b0, units_reg}))
                begin
                    state_next = S_DONE;
                end
                else if (empty_reg)
                begin
                    nx_we      = 1'b1;
                    nx_wa      = bp_reg;
                    nx_wd      = bp_reg;
                    rover_next = bp_reg;
                    empty_next = 1'b0;
                    free_next  = ({1'b0, free_reg} + {1'b0, size_q} > {1'b0, units_reg}) ?
                                 units_reg : free_reg + size_q;
                    okp_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = rover_reg;
                    steps_next = '0;
                    state_next = S_F_WALK;
                end
            end

            S_F_WALK:
            begin
                rd_addr = next_q;
                if (walk_hit)
                begin
                    sizep_next  = size_q;
                    nbnext_next = next_q;
                    state_next  = S_F_JOIN;
                end
                else if (steps_reg == units_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = next_q;
                    steps_next = steps_reg + SIZE_W'(1);
                end
            end

            S_F_JOIN:
            begin
                sz_we = 1'b1;
                sz_wa = bp_reg;
                nx_we = 1'b1;
                nx_wa = bp_reg;
                if ({1'b0, 1'b0, bp_reg} + {1'b0, bsz_reg} == {2'b00, nbnext_reg})
                begin
                    sz_wd = bsz_reg + size_q;
                    nx_wd = next_q;
                end
                else
                begin
                    sz_wd = bsz_reg;
                    nx_wd = nbnext_reg;
                end
                nbsz_next   = sz_wd;
                nbnext_next = nx_wd;
                state_next  = S_F_PJ;
            end

            S_F_PJ:
            begin
                nx_we = 1'b1;
                nx_wa = p_reg;
                if (p_end == {2'b00, bp_reg})
                begin
                    sz_we = 1'b1;
                    sz_wa = p_reg;
                    sz_wd = sizep_reg + nbsz_reg;
                    nx_wd = nbnext_reg;
                end
                else
                begin
                    nx_wd = bp_reg;
                end
                rover_next = p_reg;
                free_next  = (free_sum > {1'b0, units_reg}) ? units_reg : free_sum[SIZE_W-1:0];
                okp_next   = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.ok            = okp_reg;
                    out_next.block_address = addrp_reg;
                    out_next.free_bytes    = {free_reg, 2'b00};
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            formed_reg    <= 1'b0;
            empty_reg     <= 1'b0;
            rover_reg     <= '0;
            free_reg      <= MAX_UNITS;
            base_reg      <= '0;
            units_reg     <= MAX_UNITS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            formed_reg    <= formed_next;
            empty_reg     <= empty_next;
            rover_reg     <= rover_next;
            free_reg      <= free_next;
            base_reg      <= base_next;
            units_reg     <= units_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        prev_reg   <= prev_next;
        p_reg      <= p_next;
        blk_reg    <= blk_next;
        steps_reg  <= steps_next;
        bp_reg     <= bp_next;
        bsz_reg    <= bsz_next;
        sizep_reg  <= sizep_next;
        nbsz_reg   <= nbsz_next;
        nbnext_reg <= nbnext_next;
        okp_reg    <= okp_next;
        addrp_reg  <= addrp_next;
        out_reg    <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_empty_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> formed_reg)
        else $error("list empty without a formed list");

    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= units_reg)
        else $error("free count above heap length");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done state");
`endif

endmodule

[test/free_list_heap_allocator_test.sv]
module free_list_heap_allocator_test;

    import fal_pkg::*;

    typedef enum int {ROW_ITEM, ROW_FREE_NEWEST, ROW_FREE_OLDEST, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic               func;
        logic [COUNT_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
        bit                 chk;
        rsp_t               want;
    } row_t;

    localparam int CYCLE_LIMIT = 10000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    req_t                 in_data;
    logic                 out_valid;
    logic                 out_stall;
    rsp_t                 out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    logic [SIZE_W-1:0] hdr_size [HEAP_UNITS];
    logic [IDX_W-1:0]  hdr_next [HEAP_UNITS];
    int unsigned       rover;
    int unsigned       heap_base;
    int unsigned       heap_units;
    int unsigned       free_units;
    bit                list_formed;
    bit                list_empty;

    rsp_t              pending_rsp [$];
    logic [ADDR_W-1:0] live_blocks [$];
    int                snd_idle;
    int                rcv_idle;
    int                hold_cnt;
    bit                press_req;
    bit                press_done;
    bit                failed;
    int                cycles;

    free_list_heap_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void reform_after_config();
        list_formed = 0;
        list_empty  = 0;
        free_units  = heap_units;
    endfunction

    function automatic rsp_t predict_heap(req_t r);
        rsp_t        res;
        int unsigned need;
        int unsigned prev;
        int unsigned p;
        int unsigned nx;
        int unsigned s;
        int unsigned blk;
        int unsigned rel;
        int unsigned bp;
        int unsigned bsz;
        bit          found;
        res = '0;
        found = 0;
        if (r.func == FUNC_ALLOC) begin
            need = (int'(r.byte_count) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
            if (!list_formed) begin
                rover = 0;
                hdr_size[0] = heap_units[SIZE_W-1:0];
                hdr_next[0] = '0;
                list_formed = 1;
                list_empty = 0;
                free_units = heap_units;
            end
            if (!list_empty) begin
                prev = rover;
                p = hdr_next[prev];
                for (int unsigned steps = 0; steps <= heap_units; steps++) begin
                    s = hdr_size[p];
                    if (s >= need) begin
                        blk = p;
                        if (s == need) begin
                            if (p == prev)
                                list_empty = 1;
                            else
                                hdr_next[prev] = hdr_next[p];
                        end
                        else begin
                            hdr_size[p] = SIZE_W'(s - need);
                            blk = p + (s - need);
                            hdr_size[blk] = SIZE_W'(need);
                        end
                        rover = prev;
                        free_units = free_units > need ? free_units - need : 0;
                        res.ok = 1;
                        res.block_address = ADDR_W'(heap_base + (blk + 1) * UNIT_BYTES);
                        break;
                    end
                    if (p == rover)
                        break;
                    prev = p;
                    p = hdr_next[p];
                end
            end
        end
        else if (list_formed) begin
            rel = (int'(r.release_address) - heap_base) & 32'hFFFFF;
            bp = rel / UNIT_BYTES - 1;
            if (rel >= UNIT_BYTES && rel % UNIT_BYTES == 0 && bp < heap_units) begin
                bsz = hdr_size[bp];
                if (bsz != 0 && bp + bsz <= heap_units) begin
                    if (list_empty) begin
                        hdr_next[bp] = IDX_W'(bp);
                        rover = bp;
                        list_empty = 0;
                        found = 1;
                    end
                    else begin
                        p = rover;
                        for (int unsigned steps = 0; steps <= heap_units; steps++) begin
                            nx = hdr_next[p];
                            if ((bp > p && bp < nx) || (p >= nx && (bp > p || bp < nx))) begin
                                found = 1;
                                break;
                            end
                            p = nx;
                        end
                        if (found) begin
                            nx = hdr_next[p];
                            if (bp + bsz == nx) begin
                                hdr_size[bp] = SIZE_W'(bsz + hdr_size[nx]);
                                hdr_next[bp] = hdr_next[nx];
                            end
                            else
                                hdr_next[bp] = IDX_W'(nx);
                            if (p + hdr_size[p] == bp) begin
                                hdr_size[p] = SIZE_W'(hdr_size[p] + hdr_size[bp]);
                                hdr_next[p] = hdr_next[bp];
                            end
                            else
                                hdr_next[p] = IDX_W'(bp);
                            rover = p;
                        end
                    end
                    if (found) begin
                        free_units += bsz;
                        if (free_units > heap_units)
                            free_units = heap_units;
                        res.ok = 1;
                    end
                end
            end
        end
        res.free_bytes = FREE_W'(free_units * UNIT_BYTES);
        return res;
    endfunction

    task automatic drain();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_BASE)
            heap_base = value;
        else if (idx == CFG_HEAP_UNITS) begin
            heap_units = value[12:0];
            if (heap_units < 2)
                heap_units = 2;
            if (heap_units > HEAP_UNITS)
                heap_units = HEAP_UNITS;
        end
        reform_after_config();
        live_blocks.delete();
    endtask

    task automatic issue(req_t r, bit use_want, rsp_t want);
        rsp_t got;
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        got = predict_heap(r);
        if (r.func == FUNC_ALLOC && got.ok)
            live_blocks.push_back(got.block_address);
        pending_rsp.push_back(use_want ? want : got);
    endtask

    task automatic random_item();
        req_t        r;
        int unsigned k;
        int unsigned rel;
        r.func = FUNC_ALLOC;
        r.byte_count = COUNT_W'($urandom);
        r.release_address = ADDR_W'($urandom);
        k = $urandom_range(99);
        if (k < 6) begin
            r.func = FUNC_FREE;
            rel = (int'(r.release_address) - heap_base) & 32'hFFFFF;
            if (rel % UNIT_BYTES == 0 && rel >= UNIT_BYTES && rel / UNIT_BYTES - 1 < heap_units)
                r.release_address[0] = ~r.release_address[0];
        end
        else if (k < 52 && live_blocks.size() != 0) begin
            r.func = FUNC_FREE;
            k = $urandom_range(live_blocks.size() - 1);
            r.release_address = live_blocks[k];
            live_blocks.delete(k);
        end
        else begin
            k = $urandom_range(99);
            if (k < 70)
                r.byte_count = COUNT_W'($urandom_range(0, heap_units));
            else if (k < 90)
                r.byte_count = COUNT_W'($urandom_range(0, 16));
            else if (k < 93)
                r.byte_count = '1;
        end
        issue(r, 0, '0);
    endtask

    task automatic random_phase(int n, int s_idle, int r_idle);
        snd_idle = s_idle;
        rcv_idle = r_idle;
        repeat (n) random_item();
    endtask

    row_t rows [] = '{
        '{ROW_ITEM, FUNC_FREE, 16'd0, 20'h00004, 1, '{1'b0, 20'h0, 15'd16384}},
        '{ROW_ITEM, FUNC_ALLOC, 16'd0, 20'h0, 1, '{1'b1, 20'd16384, 15'd16380}},
        '{ROW_ITEM, FUNC_ALLOC, 16'hFFFF, 20'h0, 1, '{1'b0, 20'h0, 15'd16380}},
        '{ROW_ITEM, FUNC_FREE, 16'd0, 20'h00000, 1, '{1'b0, 20'h0, 15'd16380}},
        '{ROW_ITEM, FUNC_FREE, 16'd0, 20'h00002, 1, '{1'b0, 20'h0, 15'd16380}},
        '{ROW_ITEM, FUNC_FREE, 16'hFFFF, 20'hFFFFC, 1, '{1'b0, 20'h0, 15'd16380}},
        '{ROW_ITEM, FUNC_FREE, 16'd0, 20'd16384, 1, '{1'b1, 20'h0, 15'd16384}},
        '{ROW_ITEM, FUNC_ALLOC, 16'd100, 20'h0, 0, '0},
        '{ROW_ITEM, FUNC_ALLOC, 16'd200, 20'h0, 0, '0},
        '{ROW_ITEM, FUNC_ALLOC, 16'd1, 20'h0, 0, '0},
        '{ROW_FREE_OLDEST, FUNC_FREE, 16'd0, 20'h0, 0, '0},
        '{ROW_FREE_NEWEST, FUNC_FREE, 16'd0, 20'h0, 0, '0},
        '{ROW_FREE_NEWEST, FUNC_FREE, 16'd0, 20'h0, 0, '0},
        '{ROW_CFG, FUNC_ALLOC, 16'(CFG_HEAP_UNITS), 20'd2, 0, '0},
        '{ROW_ITEM, FUNC_ALLOC, 16'd4, 20'h0, 1, '{1'b1, 20'd4, 15'd0}},
        '{ROW_ITEM, FUNC_ALLOC, 16'd0, 20'h0, 1, '{1'b0, 20'h0, 15'd0}},
        '{ROW_FREE_NEWEST, FUNC_FREE, 16'd0, 20'h0, 1, '{1'b1, 20'h0, 15'd8}},
        '{ROW_ITEM, FUNC_ALLOC, 16'd1, 20'h0, 1, '{1'b1, 20'd4, 15'd0}},
        '{ROW_FREE_NEWEST, FUNC_FREE, 16'd0, 20'h0, 0, '0},
        '{ROW_CFG, FUNC_ALLOC, 16'(CFG_HEAP_BASE), 20'hFFFFF, 0, '0},
        '{ROW_CFG, FUNC_ALLOC, 16'(CFG_HEAP_UNITS), 20'd0, 0, '0},
        '{ROW_ITEM, FUNC_ALLOC, 16'd0, 20'h0, 1, '{1'b1, 20'h00007, 15'd4}},
        '{ROW_FREE_NEWEST, FUNC_FREE, 16'd0, 20'h0, 1, '{1'b1, 20'h0, 15'd8}},
        '{ROW_CFG, FUNC_ALLOC, 16'(CFG_HEAP_UNITS), 20'h01FFF, 0, '0},
        '{ROW_ITEM, FUNC_ALLOC, 16'd7, 20'h0, 0, '0}
    };

    always @(posedge clk)
    begin
        if (hold_cnt > 0) begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (press_req && !press_done) begin
            out_stall <= 1'b1;
            hold_cnt <= 300;
            press_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected transaction %p", $time, out_data);
                failed = 1;
            end
            else begin
                if (out_data.ok !== pending_rsp[0].ok
                    || out_data.block_address !== pending_rsp[0].block_address
                    || out_data.free_bytes !== pending_rsp[0].free_bytes) begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, pending_rsp[0], out_data);
                    failed = 1;
                end
                void'(pending_rsp.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("free_list_heap_allocator_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        hold_cnt = 0;
        press_req = 0;
        press_done = 0;
        failed = 0;
        cycles = 0;
        snd_idle = 33;
        rcv_idle = 78;
        heap_base = 0;
        heap_units = HEAP_UNITS;
        rover = 0;
        reform_after_config();
        foreach (hdr_size[i])
        begin
            hdr_size[i] = '0;
            hdr_next[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r.func = rows[i].func;
            r.byte_count = rows[i].bytes;
            r.release_address = rows[i].addr;
            case (rows[i].kind)
                ROW_CFG:
                begin
                    in_valid <= 1'b0;
                    write_reg(rows[i].bytes[CFG_IDX_W-1:0], rows[i].addr);
                end
                ROW_FREE_NEWEST:
                begin
                    r.release_address = live_blocks.pop_back();
                    issue(r, rows[i].chk, rows[i].want);
                end
                ROW_FREE_OLDEST:
                begin
                    r.release_address = live_blocks.pop_front();
                    issue(r, rows[i].chk, rows[i].want);
                end
                default:
                    issue(r, rows[i].chk, rows[i].want);
            endcase
        end

        in_valid <= 1'b0;
        write_reg(CFG_HEAP_BASE, 20'h12340);
        write_reg(CFG_HEAP_UNITS, 20'd64);
        random_phase(300, 33, 78);
        in_valid <= 1'b0;
        write_reg(CFG_HEAP_BASE, 20'hFFFF0);
        write_reg(CFG_HEAP_UNITS, 20'd300);
        random_phase(300, 78, 33);
        in_valid <= 1'b0;
        write_reg(CFG_HEAP_BASE, 20'h00000);
        write_reg(CFG_HEAP_UNITS, 20'd4096);
        press_req = 1;
        random_phase(250, 0, 0);
        in_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("free_list_heap_allocator_test: done, clean");
        else
            $display("free_list_heap_allocator_test: done, errors");
        $finish;
    end

endmodule

[filelist.f]
sv/fal_pkg.sv
sv/free_list_heap_allocator.sv
test/free_list_heap_allocator_test.sv
